>>> rtl/dsh_pkg.sv
// shared types, constants and field widths for the distinct sample history
// used by dsh_ctrl, dsh_datapath and distinct_sample_history_top
package dsh_pkg;

  // default sizes
  localparam int unsigned HistoryDepth = 12;
  localparam int unsigned DepthLimit   = 64;

  // field widths
  localparam int unsigned FuncW   = 2;
  localparam int unsigned AddrW   = 32;
  localparam int unsigned DepW    = 7;
  localparam int unsigned DepLimW = 8;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned HitW    = 32;
  localparam int unsigned LiveW   = 4;
  localparam int unsigned TotalW  = 32;

  // stream widths
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 112;
  localparam int unsigned OutUserW = 2;

  // operation codes
  typedef enum logic [FuncW-1:0] {
    FuncRecord = 2'd0,
    FuncClear  = 2'd1,
    FuncRead   = 2'd2,
    FuncNop    = 2'd3
  } dsh_func_e;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic compare;
    logic commit;
  } dsh_cmd_t;

  // one result beat
  typedef struct packed {
    logic              matched;
    logic              entry_valid;
    logic [AddrW-1:0]  entry_address;
    logic [DepW-1:0]   entry_depth;
    logic [HitW-1:0]   entry_hits;
    logic [LiveW-1:0]  live_entries;
    logic [TotalW-1:0] sample_total;
  } dsh_res_t;

endpackage

>>> rtl/dsh_ctrl.sv
// sequencing state machine: capture, compare and update steps, output valid
// depends on dsh_pkg
module dsh_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output dsh_pkg::dsh_cmd_t cmd_o
);
  import dsh_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE    = 3'b001,
    S_COMPARE = 3'b010,
    S_UPDATE  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   commit, capture, ready;

  // update may finish once the output register is free or being drained
  assign commit  = (state_q == S_UPDATE) && (!out_valid_q || m_ready_i);
  assign ready   = (state_q == S_IDLE) || commit;
  assign capture = s_valid_i && ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (capture) state_d = S_COMPARE;
      end
      S_COMPARE: begin
        state_d = S_UPDATE;
      end
      S_UPDATE: begin
        if (commit) state_d = capture ? S_COMPARE : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output beat pending
  always_comb begin
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_ready_o     = ready;
  assign m_valid_o     = out_valid_q;
  assign cmd_o.capture = capture;
  assign cmd_o.compare = (state_q == S_COMPARE);
  assign cmd_o.commit  = commit;

  // a pending beat is never overwritten before it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_ready_i) |-> !commit)
    else $error("result overwritten while pending");

  // a capture always leads straight into the compare step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    capture |=> (state_q == S_COMPARE))
    else $error("capture not followed by compare");

  // every compare step is followed by an update step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMPARE) |=> (state_q == S_UPDATE))
    else $error("compare not followed by update");

endmodule

>>> rtl/dsh_datapath.sv
// history registers, parallel address compare, counters and result register
// depends on dsh_pkg; driven by dsh_ctrl commands
module dsh_datapath #(
  parameter int unsigned HISTORY_DEPTH = dsh_pkg::HistoryDepth,
  parameter int unsigned DEPTH_LIMIT   = dsh_pkg::DepthLimit
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dsh_pkg::dsh_cmd_t           cmd_i,
  input  logic [dsh_pkg::FuncW-1:0]   func_i,
  input  logic [dsh_pkg::AddrW-1:0]   addr_i,
  input  logic [dsh_pkg::DepW-1:0]    depth_i,
  input  logic [dsh_pkg::SlotW-1:0]   slot_i,
  output dsh_pkg::dsh_res_t           res_o
);
  import dsh_pkg::*;

  localparam int unsigned IdxW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned CmpW = (CntW > SlotW) ? CntW : SlotW;
  localparam int unsigned SelW = (IdxW > SlotW) ? IdxW : SlotW;

  // captured operation
  dsh_func_e        func_q;
  logic [AddrW-1:0] addr_q;
  logic [DepW-1:0]  depth_q;
  logic [SlotW-1:0] slot_q;
  logic [DepW-1:0]  depth_sat;

  // history entries, newest at index 0
  logic [AddrW-1:0] slot_addr_q [HISTORY_DEPTH];
  logic [DepW-1:0]  slot_dep_q  [HISTORY_DEPTH];
  logic [HitW-1:0]  slot_hits_q [HISTORY_DEPTH];

  logic [CntW-1:0]          held_q, held_d;
  logic [TotalW-1:0]        total_q, total_d;
  logic [HISTORY_DEPTH-1:0] match_q, match_d;

  logic            is_rec, is_clear, hit, full;
  logic [HitW-1:0] hit_val, hit_inc;
  logic [SelW-1:0] sel_ext;
  logic [IdxW-1:0] rd_idx;
  logic [CmpW-1:0] held_ext;
  logic            rd_valid;
  dsh_res_t        res_d, res_q;

  // frame count clipped to the limit on capture
  assign depth_sat = ({1'b0, depth_i} > DepLimW'(DEPTH_LIMIT)) ? DepW'(DEPTH_LIMIT)
                                                               : depth_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q  <= dsh_func_e'(func_i);
      addr_q  <= addr_i;
      depth_q <= depth_sat;
      slot_q  <= slot_i;
    end
  end

  // compare against every live entry
  always_comb begin
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      match_d[i] = (i < int'(held_q)) && (slot_addr_q[i] == addr_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= '0;
    end else if (cmd_i.compare) begin
      match_q <= match_d;
    end
  end

  // update decode
  assign is_rec   = (func_q == FuncRecord) && (depth_q != '0);
  assign is_clear = (func_q == FuncClear);
  assign hit      = |match_q;
  assign full     = (held_q == CntW'(HISTORY_DEPTH));

  // hit count of the matching entry, one shared incrementer
  always_comb begin
    hit_val = '0;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if (match_q[i]) hit_val = hit_val | slot_hits_q[i];
    end
  end
  assign hit_inc = hit_val + HitW'(1);

  // counters after the operation
  always_comb begin
    held_d  = held_q;
    total_d = total_q;
    if (is_clear) begin
      held_d  = '0;
      total_d = '0;
    end else if (is_rec) begin
      total_d = total_q + TotalW'(1);
      if (!hit && !full) held_d = held_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      total_q <= '0;
    end else if (cmd_i.commit) begin
      held_q  <= held_d;
      total_q <= total_d;
    end
  end

  // entry update: bump the hit or shift in a new entry
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && is_rec) begin
      if (hit) begin
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
          if (match_q[i]) slot_hits_q[i] <= hit_inc;
        end
      end else begin
        for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
          slot_addr_q[i] <= slot_addr_q[i-1];
          slot_dep_q[i]  <= slot_dep_q[i-1];
          slot_hits_q[i] <= slot_hits_q[i-1];
        end
        slot_addr_q[0] <= addr_q;
        slot_dep_q[0]  <= depth_q;
        slot_hits_q[0] <= HitW'(1);
      end
    end
  end

  // read port
  assign sel_ext  = SelW'(slot_q);
  assign rd_idx   = sel_ext[IdxW-1:0];
  assign rd_valid = (func_q == FuncRead) && (CmpW'(slot_q) < CmpW'(held_q));
  assign held_ext = CmpW'(held_d);

  // result assembly
  always_comb begin
    res_d               = '0;
    res_d.matched       = is_rec && hit;
    res_d.entry_valid   = rd_valid;
    if (rd_valid) begin
      res_d.entry_address = slot_addr_q[rd_idx];
      res_d.entry_depth   = slot_dep_q[rd_idx];
      res_d.entry_hits    = slot_hits_q[rd_idx];
    end
    res_d.live_entries  = held_ext[LiveW-1:0];
    res_d.sample_total  = total_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

  // stored addresses stay distinct, so at most one entry matches
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match_q))
    else $error("more than one history entry matched");

  // fill count never exceeds the history size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CntW'(HISTORY_DEPTH))
    else $error("fill count beyond history size");

  // a record miss leaves a new front entry with one hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && is_rec && !hit) |=> (held_q != '0) && (slot_hits_q[0] == HitW'(1)))
    else $error("inserted entry malformed");

endmodule

>>> rtl/distinct_sample_history_top.sv
// top level of the distinct sample history: stream ports and beat packing
// depends on dsh_pkg, dsh_ctrl and dsh_datapath
//
// Keeps the most recently inserted distinct sample addresses, each with its
// frame count and a hit counter, plus a wrapping total of recorded samples.
// Every input beat (record, clear, read or no-op in tuser) yields exactly one
// output beat. An operation runs as a compare step, the registered parallel
// compare of the address against all live entries, then an update step of
// the entries and counters into the output register. The next beat is
// taken in the update step whenever the output register is free or being
// drained, overlapping the last commit but not a compare step; a stalled
// output holds the block there. No clearing pass is needed after reset.
module distinct_sample_history_top #(
  parameter int unsigned HISTORY_DEPTH = dsh_pkg::HistoryDepth,
  parameter int unsigned DEPTH_LIMIT   = dsh_pkg::DepthLimit
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // sample_address[31:0], sample_depth[38:32], read_slot[42:39], zero pad
  input  logic [dsh_pkg::InDataW-1:0]    s_axis_tdata_i,
  // func[1:0]
  input  logic [dsh_pkg::FuncW-1:0]      s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // entry_address[31:0], entry_depth[38:32], entry_hits[70:39],
  // live_entries[74:71], sample_total[106:75], zero pad
  output logic [dsh_pkg::OutDataW-1:0]   m_axis_tdata_o,
  // matched[0], entry_valid[1]
  output logic [dsh_pkg::OutUserW-1:0]   m_axis_tuser_o
);
  import dsh_pkg::*;

  dsh_cmd_t cmd;
  dsh_res_t res;

  // sequencing
  dsh_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .cmd_o     (cmd)
  );

  // history and counters
  dsh_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .DEPTH_LIMIT   (DEPTH_LIMIT)
  ) u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .func_i  (s_axis_tuser_i),
    .addr_i  (s_axis_tdata_i[31:0]),
    .depth_i (s_axis_tdata_i[38:32]),
    .slot_i  (s_axis_tdata_i[42:39]),
    .res_o   (res)
  );

  // output beat packing
  assign m_axis_tdata_o = {5'd0, res.sample_total, res.live_entries, res.entry_hits,
                           res.entry_depth, res.entry_address};
  assign m_axis_tuser_o = {res.entry_valid, res.matched};

endmodule
